// ----- src/sqe_pkg.sv -----
// ============================================================================
// sqe_pkg: shared types and constants for the stack/queue engine
// Command and status codes, payload structs, controller/datapath signal
// groups and circular buffer index helpers.
// ============================================================================
package sqe_pkg;

    // Store geometry
    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Command codes
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_DUMP = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;
    localparam logic [1:0] CMD_POP  = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
    } sqe_in_t;

    typedef struct packed {
        logic signed [31:0] value_res;
        logic               has_value;
        logic [1:0]         status;
        logic               last;
    } sqe_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       push;        // store the input value
        logic       pop;         // drop the front entry
        logic       ld_result;   // load a result with no entry value
        logic [1:0] res_status;  // status for ld_result
        logic       rd_first;    // read the front entry
        logic       rd_next;     // read the entry after the current one
        logic       ld_entry;    // load a result carrying the read entry
        logic       entry_last;  // last flag for ld_entry
    } sqe_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic more;      // another entry follows the one just read
        logic out_free;  // output register can take a result this cycle
    } sqe_stat_t;

    // Add two buffer positions with wrap
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (ADDR_W + 1)'(DEPTH))
        begin
            sum = sum - (ADDR_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    // Step a buffer position forward with wrap
    function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        if (a == ADDR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = a + ADDR_W'(1);
        end
        return r;
    endfunction

    // Step a buffer position backward with wrap
    function automatic logic [ADDR_W-1:0] wrap_dec(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        if (a == '0)
        begin
            r = ADDR_W'(DEPTH - 1);
        end
        else
        begin
            r = a - ADDR_W'(1);
        end
        return r;
    endfunction

endpackage

// ----- src/sqe_ctrl.sv -----
// ============================================================================
// sqe_ctrl: command sequencer for the stack/queue engine
// Decodes accepted commands, walks dump reads one entry at a time and
// drives the datapath through a command group.
// ============================================================================
module sqe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_cmd,
    output logic              in_ready,
    input  sqe_pkg::sqe_stat_t stat,
    output sqe_pkg::sqe_cmd_t  cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOAD = 1'b1;

    logic state_reg;
    logic state_next;
    logic dump_reg;
    logic dump_next;
    logic accept;

    // Take a new command only when idle and the output register has room
    assign in_ready = (state_reg == S_IDLE) && stat.out_free;
    assign accept   = in_valid && in_ready;

    // Decode and sequence
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        dump_next  = dump_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_cmd)
                        sqe_pkg::CMD_PUSH:
                        begin
                            cmd.ld_result = 1'b1;
                            if (stat.full)
                            begin
                                cmd.res_status = sqe_pkg::STAT_FULL;
                            end
                            else
                            begin
                                cmd.push       = 1'b1;
                                cmd.res_status = sqe_pkg::STAT_OK;
                            end
                        end
                        sqe_pkg::CMD_POP:
                        begin
                            cmd.ld_result = 1'b1;
                            if (stat.empty)
                            begin
                                cmd.res_status = sqe_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.pop        = 1'b1;
                                cmd.res_status = sqe_pkg::STAT_OK;
                            end
                        end
                        sqe_pkg::CMD_PEEK:
                        begin
                            if (stat.empty)
                            begin
                                cmd.ld_result  = 1'b1;
                                cmd.res_status = sqe_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.rd_first = 1'b1;
                                dump_next    = 1'b0;
                                state_next   = S_LOAD;
                            end
                        end
                        default:
                        begin
                            // Dump: an empty store gives no results
                            if (!stat.empty)
                            begin
                                cmd.rd_first = 1'b1;
                                dump_next    = 1'b1;
                                state_next   = S_LOAD;
                            end
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.ld_entry   = 1'b1;
                    cmd.entry_last = !dump_reg || !stat.more;
                    if (dump_reg && stat.more)
                    begin
                        cmd.rd_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dump_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dump_reg  <= dump_next;
        end
    end

endmodule

// ----- src/sqe_datapath.sv -----
// ============================================================================
// sqe_datapath: storage and pointers for the stack/queue engine
// Circular entry memory with front pointer and count, read register,
// dump walk index, mode register and the output register.
// ============================================================================
module sqe_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic signed [31:0] in_value,
    input  sqe_pkg::sqe_cmd_t  cmd,
    output sqe_pkg::sqe_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output sqe_pkg::sqe_out_t  out_data
);

    logic [31:0]                    mem [sqe_pkg::DEPTH];
    logic [31:0]                    rd_data_reg;
    logic [sqe_pkg::ADDR_W-1:0]     front_reg;
    logic [sqe_pkg::ADDR_W-1:0]     front_next;
    logic [sqe_pkg::CNT_W-1:0]      count_reg;
    logic [sqe_pkg::CNT_W-1:0]      count_next;
    logic [sqe_pkg::ADDR_W-1:0]     idx_reg;
    logic                           mode_reg;
    logic                           out_valid_reg;
    sqe_pkg::sqe_out_t              out_reg;
    logic [sqe_pkg::ADDR_W-1:0]     wr_addr;
    logic [sqe_pkg::ADDR_W-1:0]     rd_addr;
    logic                           rd_en;

    // Status toward the controller
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == sqe_pkg::CNT_W'(sqe_pkg::DEPTH));
    assign stat.more     = (sqe_pkg::CNT_W'(idx_reg) + sqe_pkg::CNT_W'(1)) < count_reg;
    assign stat.out_free = !out_valid_reg || out_ready;

    // Stack pushes in front of the front entry, queue pushes behind the back one
    assign wr_addr = mode_reg
                   ? sqe_pkg::wrap_add(front_reg, count_reg[sqe_pkg::ADDR_W-1:0])
                   : sqe_pkg::wrap_dec(front_reg);

    // Read the front entry first, then step through the store
    assign rd_en   = cmd.rd_first || cmd.rd_next;
    assign rd_addr = cmd.rd_first ? front_reg
                   : sqe_pkg::wrap_add(front_reg, sqe_pkg::wrap_inc(idx_reg));

    // Advance pointers
    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + sqe_pkg::CNT_W'(1);
            if (!mode_reg)
            begin
                front_next = sqe_pkg::wrap_dec(front_reg);
            end
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - sqe_pkg::CNT_W'(1);
            front_next = sqe_pkg::wrap_inc(front_reg);
        end
    end

    // Entry memory with registered read
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wr_addr] <= in_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            if (cmd.rd_first)
            begin
                idx_reg <= '0;
            end
            else if (cmd.rd_next)
            begin
                idx_reg <= idx_reg + sqe_pkg::ADDR_W'(1);
            end
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (cmd.ld_result || cmd.ld_entry)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (cmd.ld_result)
        begin
            out_reg.value_res <= '0;
            out_reg.has_value <= 1'b0;
            out_reg.status    <= cmd.res_status;
            out_reg.last      <= 1'b1;
        end
        else if (cmd.ld_entry)
        begin
            out_reg.value_res <= rd_data_reg;
            out_reg.has_value <= 1'b1;
            out_reg.status    <= sqe_pkg::STAT_OK;
            out_reg.last      <= cmd.entry_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- src/stack_queue_engine.sv -----
// ============================================================================
// stack_queue_engine: bounded stack/queue of signed 32-bit values
// Top level joining the command sequencer and the storage datapath.
// ============================================================================
// Push, pop and error results are registered and ready in the cycle after the
// command transfer, and a new command is taken in the cycle its result leaves
// the output register. Peek reads the front entry with a registered memory
// read, then loads it into the output register. Dump reads the front entry
// first, then steps through the store while the output side keeps taking
// results, since the single read port of the entry memory delivers one entry
// a cycle; no new command is taken until the last entry has moved into the
// output register. A dump of an empty store gives no results. The push order
// (stack or queue) may change between commands; stored entries stay in place.
module stack_queue_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  sqe_pkg::sqe_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output sqe_pkg::sqe_out_t out_data
);

    sqe_pkg::sqe_cmd_t  cmd;
    sqe_pkg::sqe_stat_t stat;
    logic               in_xfer;

    assign in_xfer = in_valid && in_ready;

    sqe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (in_data.cmd),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sqe_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_value    (in_data.value),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    // A non-empty peek holds off the next command while the read completes
    a_peek_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (in_data.cmd == sqe_pkg::CMD_PEEK) && !stat.empty |=> !in_ready)
        else $error("input taken during peek read");

    // Push and pop give one final result with no entry value
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && ((in_data.cmd == sqe_pkg::CMD_PUSH) || (in_data.cmd == sqe_pkg::CMD_POP))
        |=> out_valid && out_data.last && !out_data.has_value)
        else $error("push/pop result malformed");

    // A push into a full store reports it
    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (in_data.cmd == sqe_pkg::CMD_PUSH) && stat.full
        |=> out_data.status == sqe_pkg::STAT_FULL)
        else $error("full push not reported");

    // Entry results always carry ok status
    a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.has_value |-> out_data.status == sqe_pkg::STAT_OK)
        else $error("entry result with error status");

endmodule
